[design/keyword_dictionary_expander_core_defines.svh]
// Assertion macros shared by the keyword dictionary expander RTL.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef KEYWORD_DICTIONARY_EXPANDER_CORE_DEFINES_SVH
`define KEYWORD_DICTIONARY_EXPANDER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset
`define KDE_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication
`define KDE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define KDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kde_pkg.sv]
// Shared types and constants for the keyword dictionary expander.
// No dependencies; used by every module of the block.
package kde_pkg;

    // Input beat commands
    typedef enum logic [1:0] {
        CMD_DECODE = 2'd0,
        CMD_EXT_WR = 2'd1,
        CMD_KEY_WR = 2'd2,
        CMD_LEN_WR = 2'd3
    } kde_cmd_e;

    // Result error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_TRUNC    = 2'd2,
        ERR_DANGLE   = 2'd3
    } kde_err_e;

    // Walker sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_TOP,
        ST_BYTE,
        ST_ESC,
        ST_KEXT,
        ST_FIN
    } kde_state_e;

    // Keyword bytes examined per decode step before the run is cut
    localparam int WALK_LIMIT = 4096;

    // Register map: one register, word index in paddr[2]
    localparam int  APB_AW        = 3;
    localparam logic REG_EXT_COUNT = 1'b0;
    localparam logic [5:0] EXT_COUNT_RST = 6'd1;

    // Byte classes
    localparam logic [7:0] ESC_BYTE = 8'h00;

    // One input beat, unpacked
    typedef struct packed {
        kde_cmd_e    cmd;
        logic [7:0]  data;
        logic [6:0]  key_idx;
        logic [4:0]  byte_pos;
        logic [5:0]  key_len;
        logic [4:0]  ext_slot;
        logic        last;
    } kde_beat_t;

    // Store write requests (range checked)
    typedef struct packed {
        logic        kb_we;
        logic        kl_we;
        logic        ext_we;
        logic [6:0]  key_idx;
        logic [4:0]  byte_pos;
        logic [5:0]  key_len;
        logic [4:0]  ext_slot;
        logic [7:0]  data;
    } kde_wr_req_t;

    // Store read requests
    typedef struct packed {
        logic        key_rd;
        logic [6:0]  key_idx;
        logic [7:0]  key_pos;
        logic        ext_rd;
        logic [4:0]  ext_idx;
    } kde_rd_req_t;

    // Registered read data
    typedef struct packed {
        logic [7:0]  kb_data;
        logic [7:0]  kl_len;
        logic [7:0]  ext_data;
    } kde_rd_rsp_t;

    // Walker to output stage
    typedef struct packed {
        logic        put;
        logic [7:0]  ch;
        logic        fin;
        logic        fin_last;
        kde_err_e    fin_err;
    } kde_emit_t;

    // Output stage to walker
    typedef struct packed {
        logic        put_ok;
        logic        fin_ok;
    } kde_out_rdy_t;

endpackage

[design/kde_mem.sv]
// Keyword byte store, keyword length store and extended character table.
// Synchronous memories with registered read; depends on kde_pkg.
module kde_mem #(
    parameter int KEY_COUNT = 128,
    parameter int KEY_BYTES = 32,
    parameter int EXT_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kde_pkg::kde_wr_req_t wr,
    input  kde_pkg::kde_rd_req_t rd,
    output kde_pkg::kde_rd_rsp_t rsp
);
    import kde_pkg::*;

    localparam int KIW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PW    = $clog2(KEY_BYTES + 1);
    localparam int EW    = $clog2(EXT_SLOTS);
    localparam int DEPTH = KEY_COUNT * KEY_BYTES;
    localparam int KAW   = $clog2(DEPTH);

    logic [7:0]     kb_mem  [DEPTH];
    logic [PW-1:0]  kl_mem  [KEY_COUNT];
    logic [7:0]     ext_mem [EXT_SLOTS];

    logic [KEY_COUNT-1:0] kl_vld_reg;
    logic [KEY_COUNT-1:0] kl_vld_next;

    logic [7:0]     kb_q_reg;
    logic [PW-1:0]  kl_q_reg;
    logic           kl_vq_reg;
    logic [7:0]     ext_q_reg;

    logic [KAW:0]   wr_addr;
    logic [KAW:0]   rd_addr;
    logic [PW-1:0]  len_sat;

    // Flat addresses of keyword bytes
    assign wr_addr = (KAW+1)'(wr.key_idx) * (KAW+1)'(KEY_BYTES) + (KAW+1)'(wr.byte_pos);
    assign rd_addr = (KAW+1)'(rd.key_idx) * (KAW+1)'(KEY_BYTES) + (KAW+1)'(rd.key_pos);

    // Lengths above the keyword size saturate
    assign len_sat = ({2'b00, wr.key_len} > 8'(KEY_BYTES)) ? PW'(KEY_BYTES)
                                                            : PW'(wr.key_len);

    // Keyword byte memory
    always_ff @(posedge aclk) begin
        if (wr.kb_we) begin
            kb_mem[wr_addr[KAW-1:0]] <= wr.data;
        end
        if (rd.key_rd) begin
            kb_q_reg <= kb_mem[rd_addr[KAW-1:0]];
        end
    end

    // Keyword length memory
    always_ff @(posedge aclk) begin
        if (wr.kl_we) begin
            kl_mem[wr.key_idx[KIW-1:0]] <= len_sat;
        end
        if (rd.key_rd) begin
            kl_q_reg  <= kl_mem[rd.key_idx[KIW-1:0]];
            kl_vq_reg <= kl_vld_reg[rd.key_idx[KIW-1:0]];
        end
    end

    // Written flags: an unwritten length reads as zero
    always_comb begin
        kl_vld_next = kl_vld_reg;
        if (wr.kl_we) begin
            kl_vld_next[wr.key_idx[KIW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kl_vld_reg <= '0;
        end else begin
            kl_vld_reg <= kl_vld_next;
        end
    end

    // Extended character table
    always_ff @(posedge aclk) begin
        if (wr.ext_we) begin
            ext_mem[wr.ext_slot[EW-1:0]] <= wr.data;
        end
        if (rd.ext_rd) begin
            ext_q_reg <= ext_mem[rd.ext_idx[EW-1:0]];
        end
    end

    assign rsp.kb_data  = kb_q_reg;
    assign rsp.kl_len   = kl_vq_reg ? 8'(kl_q_reg) : 8'd0;
    assign rsp.ext_data = ext_q_reg;

endmodule

[design/kde_out.sv]
// Result stage: one held-back character plus the output register.
// The held character lets the final result carry last and error; uses kde_pkg.
module kde_out (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kde_pkg::kde_emit_t    emit,
    output kde_pkg::kde_out_rdy_t rdy,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_char,
    output logic                  m_char_valid,
    output logic                  m_last,
    output kde_pkg::kde_err_e     m_err
);
    import kde_pkg::*;

    logic       pend_vld_reg, pend_vld_next;
    logic [7:0] pend_char_reg, pend_char_next;
    logic       ovld_reg, ovld_next;
    logic [7:0] ochar_reg, ochar_next;
    logic       ocv_reg, ocv_next;
    logic       olast_reg, olast_next;
    kde_err_e   oerr_reg, oerr_next;
    logic       out_free;

    assign out_free   = !ovld_reg || m_ready;
    assign rdy.put_ok = !pend_vld_reg || out_free;
    assign rdy.fin_ok = out_free;

    // Held character moves out when a newer one arrives or the step ends
    always_comb begin
        pend_vld_next  = pend_vld_reg;
        pend_char_next = pend_char_reg;
        ovld_next      = ovld_reg && !m_ready;
        ochar_next     = ochar_reg;
        ocv_next       = ocv_reg;
        olast_next     = olast_reg;
        oerr_next      = oerr_reg;
        if (emit.put) begin
            if (pend_vld_reg) begin
                ovld_next  = 1'b1;
                ochar_next = pend_char_reg;
                ocv_next   = 1'b1;
                olast_next = 1'b0;
                oerr_next  = ERR_NONE;
            end
            pend_vld_next  = 1'b1;
            pend_char_next = emit.ch;
        end else if (emit.fin) begin
            if (pend_vld_reg) begin
                ovld_next     = 1'b1;
                ochar_next    = pend_char_reg;
                ocv_next      = 1'b1;
                olast_next    = emit.fin_last;
                oerr_next     = emit.fin_err;
                pend_vld_next = 1'b0;
            end else if (emit.fin_last || (emit.fin_err != ERR_NONE)) begin
                // end-only marker
                ovld_next  = 1'b1;
                ochar_next = 8'd0;
                ocv_next   = 1'b0;
                olast_next = emit.fin_last;
                oerr_next  = emit.fin_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            ovld_reg     <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            ovld_reg     <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_char_reg <= pend_char_next;
        ochar_reg     <= ochar_next;
        ocv_reg       <= ocv_next;
        olast_reg     <= olast_next;
        oerr_reg      <= oerr_next;
    end

    assign m_valid      = ovld_reg;
    assign m_char       = ochar_reg;
    assign m_char_valid = ocv_reg;
    assign m_last       = olast_reg;
    assign m_err        = oerr_reg;

endmodule

[design/kde_walker.sv]
// Decode sequencer: classifies input bytes and walks nested keywords
// through the store memories with a small nesting stack. Uses kde_pkg.
`include "keyword_dictionary_expander_core_defines.svh"

module kde_walker #(
    parameter int KEY_COUNT   = 128,
    parameter int KEY_BYTES   = 32,
    parameter int EXT_SLOTS   = 32,
    parameter int STACK_DEPTH = 8,
    parameter int MAX_RUN     = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kde_pkg::kde_beat_t    beat,
    input  logic [5:0]            ext_count,
    output kde_pkg::kde_rd_req_t  rd_req,
    input  kde_pkg::kde_rd_rsp_t  rd_rsp,
    output kde_pkg::kde_emit_t    emit,
    input  kde_pkg::kde_out_rdy_t out_rdy
);
    import kde_pkg::*;

    localparam int KIW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PW  = $clog2(KEY_BYTES + 1);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int STW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_RUN + 1);
    localparam int WW  = $clog2(WALK_LIMIT + 1);

    kde_state_e     state_reg, state_next;
    logic           esc_reg, esc_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [WW-1:0]  walked_reg, walked_next;
    kde_err_e       err_reg, err_next;
    logic           stop_reg, stop_next;
    logic           last_reg, last_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [KIW-1:0] cur_key_reg, cur_key_next;
    logic [PW-1:0]  cur_pos_reg, cur_pos_next;

    // Nesting stack: keyword number and next byte offset per level
    logic [KIW-1:0] stk_key_reg [STACK_DEPTH];
    logic [PW-1:0]  stk_pos_reg [STACK_DEPTH];

    logic           upd_en;
    logic [STW-1:0] upd_idx;
    logic [PW-1:0]  upd_pos;
    logic           push_en;
    logic [STW-1:0] push_idx;
    logic [KIW-1:0] push_key;

    logic [STW-1:0] stk_top;
    logic [PW-1:0]  len;
    logic [7:0]     kb;
    logic [PW-1:0]  pos1;
    logic           byte_live;
    logic           walk_full;
    logic           want_put;
    logic [7:0]     put_ch;
    logic           put_go;
    logic           stall;

    function automatic logic is_mapped(input logic [7:0] b, input logic [5:0] cnt);
        is_mapped = (b != ESC_BYTE) && (b < {2'b00, cnt}) && (b < 8'(EXT_SLOTS));
    endfunction

    function automatic kde_err_e first_err(input kde_err_e cur, input kde_err_e nw);
        first_err = (cur == ERR_NONE) ? nw : cur;
    endfunction

    assign stk_top   = STW'(sp_reg - SPW'(1));
    assign len       = rd_rsp.kl_len[PW-1:0];
    assign kb        = rd_rsp.kb_data;
    assign pos1      = cur_pos_reg + PW'(1);
    assign byte_live = cur_pos_reg < len;
    assign walk_full = walked_reg == WW'(WALK_LIMIT);
    assign in_ready  = state_reg == ST_IDLE;

    // Character produced in this state, before run budget and stall
    always_comb begin
        want_put = 1'b0;
        put_ch   = rd_rsp.ext_data;
        case (state_reg)
            ST_EXT, ST_KEXT: begin
                want_put = 1'b1;
            end
            ST_ESC: begin
                want_put = 1'b1;
                put_ch   = kb;
            end
            ST_BYTE: begin
                if (byte_live && !walk_full && (kb != ESC_BYTE)
                        && !is_mapped(kb, ext_count) && !kb[7]) begin
                    want_put = 1'b1;
                    put_ch   = kb;
                end
            end
            default: begin
                want_put = 1'b0;
            end
        endcase
    end

    assign put_go = want_put && !stop_reg && (count_reg != CW'(MAX_RUN));
    assign stall  = put_go && !out_rdy.put_ok;

    // Next state and datapath control
    always_comb begin
        state_next   = state_reg;
        esc_next     = esc_reg;
        count_next   = count_reg;
        walked_next  = walked_reg;
        err_next     = err_reg;
        stop_next    = stop_reg;
        last_next    = last_reg;
        sp_next      = sp_reg;
        cur_key_next = cur_key_reg;
        cur_pos_next = cur_pos_reg;
        upd_en       = 1'b0;
        upd_idx      = stk_top;
        upd_pos      = pos1;
        push_en      = 1'b0;
        push_idx     = STW'(sp_reg);
        push_key     = KIW'(kb[6:0]);
        rd_req       = '0;
        emit         = '0;

        if (!stall) begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid && (beat.cmd == CMD_DECODE)) begin
                        count_next  = '0;
                        walked_next = '0;
                        err_next    = ERR_NONE;
                        stop_next   = 1'b0;
                        last_next   = beat.last;
                        sp_next     = '0;
                        state_next  = ST_FIN;
                        if (esc_reg) begin
                            esc_next   = 1'b0;
                            emit.put   = 1'b1;
                            emit.ch    = beat.data;
                            count_next = CW'(1);
                        end else if (beat.data == ESC_BYTE) begin
                            if (beat.last) begin
                                err_next = ERR_DANGLE;
                            end else begin
                                esc_next = 1'b1;
                            end
                        end else if (is_mapped(beat.data, ext_count)) begin
                            rd_req.ext_rd  = 1'b1;
                            rd_req.ext_idx = beat.data[4:0];
                            state_next     = ST_EXT;
                        end else if (beat.data[7]) begin
                            // keyword reference opens the walk
                            if ({1'b0, beat.data[6:0]} < 8'(KEY_COUNT)) begin
                                push_en  = 1'b1;
                                push_idx = '0;
                                push_key = KIW'(beat.data[6:0]);
                                sp_next  = SPW'(1);
                            end
                            state_next = ST_TOP;
                        end else begin
                            emit.put   = 1'b1;
                            emit.ch    = beat.data;
                            count_next = CW'(1);
                        end
                        if (beat.last) begin
                            esc_next = 1'b0;
                        end
                    end
                end
                ST_EXT: begin
                    state_next = ST_FIN;
                end
                ST_TOP: begin
                    if ((sp_reg == '0) || stop_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        cur_key_next   = stk_key_reg[stk_top];
                        cur_pos_next   = stk_pos_reg[stk_top];
                        rd_req.key_rd  = 1'b1;
                        rd_req.key_idx = 7'(stk_key_reg[stk_top]);
                        rd_req.key_pos = 8'(stk_pos_reg[stk_top]);
                        state_next     = ST_BYTE;
                    end
                end
                ST_BYTE: begin
                    if (!byte_live) begin
                        // keyword finished: pop
                        sp_next    = sp_reg - SPW'(1);
                        state_next = ST_TOP;
                    end else if (walk_full) begin
                        err_next   = first_err(err_reg, ERR_TRUNC);
                        stop_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        walked_next = walked_reg + WW'(1);
                        if (kb == ESC_BYTE) begin
                            if (pos1 < len) begin
                                rd_req.key_rd  = 1'b1;
                                rd_req.key_idx = 7'(cur_key_reg);
                                rd_req.key_pos = 8'(pos1);
                                state_next     = ST_ESC;
                            end else begin
                                // escape on the final byte is dropped
                                upd_en     = 1'b1;
                                state_next = ST_TOP;
                            end
                        end else if (is_mapped(kb, ext_count)) begin
                            upd_en         = 1'b1;
                            rd_req.ext_rd  = 1'b1;
                            rd_req.ext_idx = kb[4:0];
                            state_next     = ST_KEXT;
                        end else if (kb[7]) begin
                            upd_en = 1'b1;
                            if ({1'b0, kb[6:0]} < 8'(KEY_COUNT)) begin
                                if (sp_reg == SPW'(STACK_DEPTH)) begin
                                    err_next = first_err(err_reg, ERR_OVERFLOW);
                                end else begin
                                    push_en = 1'b1;
                                    sp_next = sp_reg + SPW'(1);
                                end
                            end
                            state_next = ST_TOP;
                        end else begin
                            upd_en     = 1'b1;
                            state_next = ST_TOP;
                        end
                    end
                end
                ST_ESC: begin
                    upd_en     = 1'b1;
                    upd_pos    = cur_pos_reg + PW'(2);
                    state_next = ST_TOP;
                end
                ST_KEXT: begin
                    state_next = ST_TOP;
                end
                ST_FIN: begin
                    if (out_rdy.fin_ok) begin
                        emit.fin      = 1'b1;
                        emit.fin_last = last_reg;
                        emit.fin_err  = err_reg;
                        sp_next       = '0;
                        state_next    = ST_IDLE;
                    end
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase

            // Run budget on walker characters
            if (want_put) begin
                if (put_go) begin
                    emit.put   = 1'b1;
                    emit.ch    = put_ch;
                    count_next = count_reg + CW'(1);
                end else if (!stop_reg) begin
                    err_next  = first_err(err_reg, ERR_TRUNC);
                    stop_next = 1'b1;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            walked_reg <= '0;
            err_reg    <= ERR_NONE;
            stop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            sp_reg     <= '0;
        end else begin
            state_reg  <= state_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            walked_reg <= walked_next;
            err_reg    <= err_next;
            stop_reg   <= stop_next;
            last_reg   <= last_next;
            sp_reg     <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_key_reg <= cur_key_next;
        cur_pos_reg <= cur_pos_next;
    end

    // Stack entries: offset update at the top, push one above
    always_ff @(posedge aclk) begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (upd_en && (upd_idx == STW'(i))) begin
                stk_pos_reg[i] <= upd_pos;
            end
            if (push_en && (push_idx == STW'(i))) begin
                stk_key_reg[i] <= push_key;
                stk_pos_reg[i] <= '0;
            end
        end
    end

    `KDE_ASSERT_IMPLIES(a_put_in_budget, emit.put && (state_reg != ST_IDLE), !stop_reg && (count_reg < CW'(MAX_RUN)), "character emitted past run budget")
    `KDE_ASSERT_IMPLIES(a_stop_has_err, stop_reg, err_reg != ERR_NONE, "run stopped without an error code")
    `KDE_ASSERT_IMPLIES(a_walk_has_level, (state_reg == ST_BYTE) || (state_reg == ST_ESC), sp_reg != '0, "keyword byte read with empty stack")
    `KDE_ASSERT_NEXT(a_fin_to_idle, emit.fin, (state_reg == ST_IDLE) && (sp_reg == '0), "step end did not return to idle")
    `KDE_ASSERT_HOLDS(a_sp_bound, sp_reg <= SPW'(STACK_DEPTH), "nesting pointer beyond stack depth")

endmodule

[design/keyword_dictionary_expander_core.sv]
// Keyword dictionary expander. Load beats (table slot, keyword byte,
// keyword length) give no result. A decode beat of a plain or escaped byte
// emits that byte, a byte mapped through the extended table reads its slot,
// and a keyword reference walks the stored keyword bytes through the
// registered reads of the keyword memories, handling escape pairs, mapped
// bytes and nested keywords and checking each entered keyword for its end.
// Stalls on the result channel hold the walk. The next beat is taken once
// the step's final result has been handed to the output register. Stored
// lengths reset to zero through per-keyword written flags, so no clearing
// pass follows reset.
// Depends on kde_pkg, kde_mem, kde_walker and kde_out.
module keyword_dictionary_expander_core #(
    parameter int KEY_COUNT   = 128,
    parameter int KEY_BYTES   = 32,
    parameter int EXT_SLOTS   = 32,
    parameter int STACK_DEPTH = 8,
    parameter int MAX_RUN     = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // data_byte[7:0], key_index[14:8], byte_position[19:15],
    // key_length[25:20], ext_slot[30:26], zero[31]
    input  logic [31:0]                s_tdata,
    // command[1:0]
    input  logic [1:0]                 s_tuser,
    input  logic                       s_tlast,
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // char_out[7:0], error[9:8], zero[15:10]
    output logic [15:0]                m_tdata,
    // char_valid[0]
    output logic                       m_tuser,
    output logic                       m_tlast,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kde_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import kde_pkg::*;

    logic [5:0]    ext_count_reg, ext_count_next;
    kde_beat_t     beat;
    kde_wr_req_t   wr;
    kde_rd_req_t   rd_req;
    kde_rd_rsp_t   rd_rsp;
    kde_emit_t     emit;
    kde_out_rdy_t  out_rdy;
    logic          acc;
    logic [7:0]    o_char;
    kde_err_e      o_err;

    // Configuration register
    assign pready = 1'b1;

    always_comb begin
        ext_count_next = ext_count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_EXT_COUNT)) begin
            ext_count_next = pwdata[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_count_reg <= EXT_COUNT_RST;
        end else begin
            ext_count_reg <= ext_count_next;
        end
    end

    assign prdata = (paddr[2] == REG_EXT_COUNT) ? 32'(ext_count_reg) : 32'd0;

    // Input beat fields
    assign beat.cmd      = kde_cmd_e'(s_tuser);
    assign beat.data     = s_tdata[7:0];
    assign beat.key_idx  = s_tdata[14:8];
    assign beat.byte_pos = s_tdata[19:15];
    assign beat.key_len  = s_tdata[25:20];
    assign beat.ext_slot = s_tdata[30:26];
    assign beat.last     = s_tlast;

    assign acc = s_tvalid && s_tready;

    // Load commands write the stores; out-of-range writes are dropped
    assign wr.ext_we   = acc && (beat.cmd == CMD_EXT_WR)
                         && (6'(beat.ext_slot) < 6'(EXT_SLOTS));
    assign wr.kb_we    = acc && (beat.cmd == CMD_KEY_WR)
                         && ({1'b0, beat.key_idx} < 8'(KEY_COUNT))
                         && (8'(beat.byte_pos) < 8'(KEY_BYTES));
    assign wr.kl_we    = acc && (beat.cmd == CMD_LEN_WR)
                         && ({1'b0, beat.key_idx} < 8'(KEY_COUNT));
    assign wr.key_idx  = beat.key_idx;
    assign wr.byte_pos = beat.byte_pos;
    assign wr.key_len  = beat.key_len;
    assign wr.ext_slot = beat.ext_slot;
    assign wr.data     = beat.data;

    kde_mem #(
        .KEY_COUNT (KEY_COUNT),
        .KEY_BYTES (KEY_BYTES),
        .EXT_SLOTS (EXT_SLOTS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd_req),
        .rsp     (rd_rsp)
    );

    kde_walker #(
        .KEY_COUNT   (KEY_COUNT),
        .KEY_BYTES   (KEY_BYTES),
        .EXT_SLOTS   (EXT_SLOTS),
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_RUN     (MAX_RUN)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .beat      (beat),
        .ext_count (ext_count_reg),
        .rd_req    (rd_req),
        .rd_rsp    (rd_rsp),
        .emit      (emit),
        .out_rdy   (out_rdy)
    );

    kde_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .emit         (emit),
        .rdy          (out_rdy),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_char       (o_char),
        .m_char_valid (m_tuser),
        .m_last       (m_tlast),
        .m_err        (o_err)
    );

    assign m_tdata = {6'd0, o_err, o_char};

endmodule

[test/tb_top.sv]
// Self-checking bench for keyword_dictionary_expander_core: drives load and decode beats,
// predicts every expanded character and compares each result beat field by field.
// Depends on kde_pkg and the expander RTL; no files, plusargs or external code.
module tb_top;
    import kde_pkg::*;

    localparam int KEYS       = 128;
    localparam int KW_BYTES   = 32;
    localparam int TBL_SLOTS  = 32;
    localparam int NEST_DEPTH = 8;
    localparam int RUN_MAX    = 64;
    localparam int IDLE_LIMIT = 50000;
    localparam int PHASE_BEATS = 52;
    localparam logic [2:0] EXT_COUNT_ADDR = {REG_EXT_COUNT, 2'b00};
    localparam logic [7:0] KEY_FLAG = 8'h80;

    // One result beat as the block should present it
    typedef struct packed {
        logic [7:0] ch;
        logic       vld;
        logic       lst;
        kde_err_e   err;
    } char_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = CMD_DECODE;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    keyword_dictionary_expander_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Expander shadow: stores, register and per-step scratch
    // ------------------------------------------------------------------
    logic [7:0] ext_tbl [TBL_SLOTS];
    logic [7:0] kw_mem [KEYS*KW_BYTES];
    bit   [5:0] kw_len [KEYS];
    bit         esc_pend;
    logic [5:0] ext_lim = EXT_COUNT_RST;
    logic [7:0] step_chars [$];
    kde_err_e   step_err = ERR_NONE;
    bit         step_halt;
    logic [6:0] nest_key [NEST_DEPTH];
    int         nest_pos [NEST_DEPTH];
    int         nest_sp;
    char_res_t  char_results [$];

    // Stimulus side
    kde_beat_t  beats_to_send [$];
    kde_beat_t  beat_on_bus;
    int         beats_left;
    int         items_made;
    bit         kb_set [KEYS*KW_BYTES];
    logic [7:0] kw_body [$];
    logic [7:0] code_run [$];
    int         s_wait, m_hold, quiet, mism;
    bit         s_calm, m_calm;

    function automatic bit is_mapped(input logic [7:0] b);
        return (b != ESC_BYTE) && (b < {2'b00, ext_lim}) && (b < TBL_SLOTS);
    endfunction

    // First error of a step wins
    task automatic flag_err(input kde_err_e e);
        if (step_err == ERR_NONE) step_err = e;
    endtask

    task automatic put_ch(input logic [7:0] c);
        if (step_halt) return;
        if (step_chars.size() >= RUN_MAX) begin
            flag_err(ERR_TRUNC);
            step_halt = 1'b1;
            return;
        end
        step_chars.push_back(c);
    endtask

    task automatic nest_push(input logic [6:0] k);
        if (nest_sp >= NEST_DEPTH) begin
            flag_err(ERR_OVERFLOW);
        end else begin
            nest_key[nest_sp] = k;
            nest_pos[nest_sp] = 0;
            nest_sp++;
        end
    endtask

    // Walk a keyword and everything it references, depth first
    task automatic expand_keyword(input logic [6:0] k);
        int         walked, top, pos, len;
        logic [6:0] kk;
        logic [7:0] c;
        walked = 0;
        nest_sp = 0;
        nest_push(k);
        while (nest_sp > 0 && !step_halt) begin
            top = nest_sp - 1;
            kk  = nest_key[top];
            pos = nest_pos[top];
            len = kw_len[kk];
            if (pos >= len) begin
                nest_sp--;
                continue;
            end
            walked++;
            if (walked > WALK_LIMIT) begin
                flag_err(ERR_TRUNC);
                step_halt = 1'b1;
                break;
            end
            c = kw_mem[{kk, pos[4:0]}];
            pos++;
            if (c == ESC_BYTE) begin
                // escape on the final keyword byte is dropped
                if (pos < len) begin
                    put_ch(kw_mem[{kk, pos[4:0]}]);
                    pos++;
                end
            end else if (is_mapped(c)) begin
                put_ch(ext_tbl[c[4:0]]);
            end else if (c[7]) begin
                nest_pos[top] = pos;
                nest_push(c[6:0]);
                continue;
            end else begin
                put_ch(c);
            end
            nest_pos[top] = pos;
        end
        nest_sp = 0;
    endtask

    // One decode step: expand a compacted byte into result beats
    task automatic decode_step(input logic [7:0] d, input logic lst);
        char_res_t r;
        step_chars.delete();
        step_err  = ERR_NONE;
        step_halt = 1'b0;
        if (esc_pend) begin
            esc_pend = 1'b0;
            put_ch(d);
        end else if (d == ESC_BYTE) begin
            if (lst) flag_err(ERR_DANGLE);
            else esc_pend = 1'b1;
        end else if (is_mapped(d)) begin
            put_ch(ext_tbl[d[4:0]]);
        end else if (d[7]) begin
            expand_keyword(d[6:0]);
        end else begin
            put_ch(d);
        end
        if (lst) esc_pend = 1'b0;
        if (step_chars.size() == 0) begin
            // end-only marker
            if (lst || step_err != ERR_NONE) begin
                r = '{ch: 8'h00, vld: 1'b0, lst: lst, err: step_err};
                char_results.push_back(r);
            end
        end else begin
            foreach (step_chars[i]) begin
                r.ch  = step_chars[i];
                r.vld = 1'b1;
                r.lst = (i == step_chars.size() - 1) && lst;
                r.err = (i == step_chars.size() - 1) ? step_err : ERR_NONE;
                char_results.push_back(r);
            end
        end
    endtask

    task automatic predict_beat(input kde_beat_t b);
        case (b.cmd)
            CMD_EXT_WR: ext_tbl[b.ext_slot] = b.data;
            CMD_KEY_WR: kw_mem[{b.key_idx, b.byte_pos}] = b.data;
            CMD_LEN_WR: kw_len[b.key_idx] = (b.key_len > KW_BYTES) ? 6'(KW_BYTES) : b.key_len;
            default:    decode_step(b.data, b.last);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Unused fields carry random junk
    task automatic enqueue(input kde_cmd_e c, input logic [7:0] d, input logic [6:0] k,
                           input logic [4:0] p, input logic [5:0] l, input logic [4:0] sl,
                           input logic lst);
        kde_beat_t b;
        b.cmd      = c;
        b.data     = d;
        b.key_idx  = k;
        b.byte_pos = p;
        b.key_len  = l;
        b.ext_slot = sl;
        b.last     = lst;
        beats_to_send.push_back(b);
        beats_left++;
        items_made++;
    endtask

    task automatic load_ext(input logic [4:0] sl, input logic [7:0] v);
        enqueue(CMD_EXT_WR, v, 7'($urandom), 5'($urandom), 6'($urandom_range(0, 32)), sl,
                1'($urandom));
    endtask

    task automatic load_kw_byte(input logic [6:0] k, input logic [4:0] p, input logic [7:0] v);
        kb_set[{k, p}] = 1'b1;
        enqueue(CMD_KEY_WR, v, k, p, 6'($urandom_range(0, 32)), 5'($urandom), 1'($urandom));
    endtask

    task automatic load_kw_len(input logic [6:0] k, input logic [5:0] l);
        enqueue(CMD_LEN_WR, 8'($urandom), k, 5'($urandom), l, 5'($urandom), 1'($urandom));
    endtask

    task automatic send_code(input logic [7:0] d, input logic lst);
        enqueue(CMD_DECODE, d, 7'($urandom), 5'($urandom), 6'($urandom_range(0, 32)),
                5'($urandom), lst);
    endtask

    // Store kw_body as keyword k: bytes first, then the length
    task automatic define_keyword(input logic [6:0] k);
        foreach (kw_body[i]) load_kw_byte(k, 5'(i), kw_body[i]);
        load_kw_len(k, 6'(kw_body.size()));
    endtask

    function automatic logic [6:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return 7'($urandom_range(32, 47));
        if (r < 97) return 7'($urandom_range(1, 5));
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_code(input int ref_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ref_pct) return KEY_FLAG | {1'b0, pick_key()};
        r = $urandom_range(0, 99);
        if (r < 20) return 8'($urandom_range(1, 31));
        if (r < 95) return 8'($urandom_range(32, 127));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic fill_body(input int n);
        kw_body.delete();
        while (kw_body.size() < n) begin
            if ($urandom_range(0, 99) < 10) begin
                kw_body.push_back(ESC_BYTE);
                if (kw_body.size() < n) kw_body.push_back(8'($urandom));
            end else begin
                kw_body.push_back(pick_code(15));
            end
        end
    endtask

    // A compacted string; a few end on a bare escape or leave last low
    task automatic send_run();
        int  n;
        bit  open_end;
        n = $urandom_range(1, 6);
        code_run.delete();
        while (code_run.size() < n) begin
            if ($urandom_range(0, 99) < 12) begin
                code_run.push_back(ESC_BYTE);
                code_run.push_back(8'($urandom));
            end else begin
                code_run.push_back(pick_code(30));
            end
        end
        if ($urandom_range(0, 99) < 8) code_run.push_back(ESC_BYTE);
        open_end = ($urandom_range(0, 99) < 8);
        foreach (code_run[i]) send_code(code_run[i], (i == code_run.size() - 1) && !open_end);
    endtask

    task automatic random_phase(input int count);
        int         stop_at, r, p;
        logic [6:0] k;
        stop_at = items_made + count;
        while (items_made < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 18) begin
                k = ($urandom_range(0, 99) < 90) ? 7'($urandom_range(32, 47))
                                                 : 7'($urandom_range(0, 127));
                fill_body(($urandom_range(0, 99) < 80) ? $urandom_range(0, 8)
                                                       : $urandom_range(9, KW_BYTES));
                define_keyword(k);
            end else if (r < 20) begin
                load_ext(5'($urandom), 8'($urandom));
            end else if (r < 22) begin
                load_kw_byte(7'($urandom), 5'($urandom), 8'($urandom));
            end else if (r < 24) begin
                // length never covers a byte that was not stored
                k = pick_key();
                p = 0;
                while (p < KW_BYTES && kb_set[{k, p[4:0]}]) p++;
                load_kw_len(k, 6'($urandom_range(0, p)));
            end else begin
                send_run();
            end
        end
    endtask

    // Register write: setup cycle, then access cycle
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ext_lim = val[5:0];
    endtask

    task automatic drain_and_settle(input int settle);
        while (beats_left != 0 || char_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Input driver: one beat per handshake, random gaps between beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_beat(beat_on_bus);
                beats_left--;
            end
            if (!s_tvalid || s_tready) begin
                if (s_wait > 0 || beats_to_send.size() == 0) begin
                    if (s_wait > 0) s_wait--;
                    s_tvalid <= 1'b0;
                end else begin
                    beat_on_bus = beats_to_send.pop_front();
                    // data, key index, byte position, key length, slot, pad bit
                    s_tdata  <= {1'b0, beat_on_bus.ext_slot, beat_on_bus.key_len,
                                 beat_on_bus.byte_pos, beat_on_bus.key_idx, beat_on_bus.data};
                    s_tuser  <= beat_on_bus.cmd;
                    s_tlast  <= beat_on_bus.last;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 63) == 0) s_calm = !s_calm;
                    s_wait = pick_gap(s_calm);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random backpressure, compare with oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        char_res_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{ch: m_tdata[7:0], vld: m_tuser, lst: m_tlast,
                        err: kde_err_e'(m_tdata[9:8])};
                if (char_results.size() == 0) begin
                    mism++;
                    if (mism <= 10)
                        $display("unexpected result beat: ch=%h vld=%b last=%b err=%0d",
                                 got.ch, got.vld, got.lst, got.err);
                end else begin
                    want = char_results.pop_front();
                    if (got.ch !== want.ch || got.vld !== want.vld ||
                        got.lst !== want.lst || got.err !== want.err) begin
                        mism++;
                        if (mism <= 10) begin
                            $write("result mismatch: expected ch=%h vld=%b last=%b err=%0d,",
                                   want.ch, want.vld, want.lst, want.err);
                            $display(" got ch=%h vld=%b last=%b err=%0d",
                                     got.ch, got.vld, got.lst, got.err);
                        end
                    end
                end
                if ($urandom_range(0, 63) == 0) m_calm = !m_calm;
                m_hold = pick_gap(m_calm);
            end
            if (m_hold > 0) begin
                m_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [5:0] ext_plan [6];
        ext_plan = '{6'd32, 6'($urandom_range(2, 31)), 6'd1,
                     6'($urandom_range(2, 31)), 6'd32, 6'($urandom_range(2, 31))};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Whole extended table first, so no mapped byte reads an empty slot
        for (int s = 0; s < TBL_SLOTS; s++) begin
            if (s == 1) load_ext(5'(s), 8'hff);
            else if (s == TBL_SLOTS - 1) load_ext(5'(s), 8'h00);
            else load_ext(5'(s), 8'($urandom));
        end

        // Plain bytes, escapes and empty keywords with nothing mapped
        send_code(8'h01, 1'b0);
        send_code(8'h7f, 1'b1);
        send_code(ESC_BYTE, 1'b0);
        send_code(ESC_BYTE, 1'b1);
        send_code(ESC_BYTE, 1'b0);
        send_code(8'hff, 1'b0);
        send_code(ESC_BYTE, 1'b1);      // dangling escape
        send_code(8'h80, 1'b0);         // empty keyword, silent step
        send_code(8'hff, 1'b1);         // empty keyword, end-only marker

        // Keyword 2: 32 literal characters
        kw_body.delete();
        for (int i = 0; i < KW_BYTES; i++) kw_body.push_back(8'(8'h60 + i));
        define_keyword(7'd2);
        // Keyword 1: literal, escaped reference, nested keyword, unmapped low byte, trailing escape
        kw_body = '{8'h41, ESC_BYTE, 8'h85, 8'h82, 8'h03, ESC_BYTE};
        define_keyword(7'd1);
        // Keyword 3 overflows the run, keyword 4 refers to itself until the stack fills
        kw_body = '{8'h82, 8'h82, 8'h82};
        define_keyword(7'd3);
        kw_body = '{8'h84};
        define_keyword(7'd4);
        // Keywords 10..16: four references each down a chain to empty keyword 17
        for (int k = 10; k <= 16; k++) begin
            kw_body = '{KEY_FLAG | 8'(k + 1), KEY_FLAG | 8'(k + 1),
                        KEY_FLAG | 8'(k + 1), KEY_FLAG | 8'(k + 1)};
            define_keyword(7'(k));
        end

        send_code(8'h81, 1'b1);
        send_code(8'h83, 1'b1);         // run truncation
        send_code(8'h84, 1'b0);         // nesting overflow
        send_code(8'h8a, 1'b1);         // walk limit
        send_code(8'h82, 1'b0);
        send_code(8'h03, 1'b1);
        drain_and_settle(16);

        for (int ph = 0; ph < 6; ph++) begin
            apb_write(EXT_COUNT_ADDR, {26'd0, ext_plan[ph]});
            if (ph == 0) begin
                // everything below the limit now maps
                send_code(8'h1f, 1'b0);
                send_code(8'h01, 1'b0);
                send_code(ESC_BYTE, 1'b0);
                send_code(8'h05, 1'b0);
                send_code(8'h81, 1'b1);
            end
            random_phase(PHASE_BEATS);
            // close the phase with a step that always answers
            send_code(8'($urandom_range(32, 127)), 1'b1);
            drain_and_settle(16);
        end

        drain_and_settle(64);
        if (mism == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
